### rtl/core/matrix3_inverse_unit_macros.svh
// Assertion macros for the matrix3 inverse unit.
// Included by the RTL files that carry concurrent assertions.
`ifndef MATRIX3_INVERSE_UNIT_MACROS_SVH
`define MATRIX3_INVERSE_UNIT_MACROS_SVH

// check a consequent in the same cycle as the antecedent
`define M3I_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m3i assertion failed");

// check a consequent delayed from the antecedent by the argument n
`define M3I_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("m3i assertion failed");

`endif

### rtl/core/m3i_pkg.sv
// Types and constants shared by the matrix3 inverse unit.
// No dependencies.
package m3i_pkg;

    localparam int ELEM_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int EPS_W   = 17;
    localparam int NELEM   = 9;
    localparam int NPROD   = 18;
    localparam int NTOP    = 3;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int COF_W   = PROD_W + 1;
    localparam int HI_W    = COF_W - ELEM_W;
    localparam int PP_W    = ELEM_W + HI_W;
    localparam int DET_W   = 3 * ELEM_W + 1;
    localparam int MAG_W   = DET_W - 1;
    localparam int QUO_W   = ELEM_W + 1;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [PP_W-1:0]   pp_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic        [MAG_W-1:0]  mag_t;
    typedef logic        [QUO_W-1:0]  quo_t;
    typedef logic        [EPS_W-1:0]  eps_t;

    // product operands: cofactor i is prod(2i) - prod(2i+1), elements row-major
    localparam int unsigned PROD_L [NPROD] =
        '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int unsigned PROD_R [NPROD] =
        '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

    typedef struct packed {
        elem_t a00;
        elem_t a01;
        elem_t a02;
        elem_t a10;
        elem_t a11;
        elem_t a12;
        elem_t a20;
        elem_t a21;
        elem_t a22;
    } item_t;

    typedef struct packed {
        elem_t b00;
        elem_t b01;
        elem_t b02;
        elem_t b10;
        elem_t b11;
        elem_t b12;
        elem_t b20;
        elem_t b21;
        elem_t b22;
        logic  singular;
        logic  saturated;
    } result_t;

    typedef struct packed {
        prod_t [NPROD-1:0] prod;
        elem_t [NTOP-1:0]  top;
    } fq_t;

    typedef struct packed {
        mag_t              det_mag;
        logic              det_neg;
        logic              sing;
        mag_t [NELEM-1:0]  num_mag;
        logic [NELEM-1:0]  num_neg;
    } dv_t;

endpackage

### rtl/core/m3i_front.sv
// Front end: accepts a matrix beat and forms the eighteen element products.
// Depends on m3i_pkg.
module m3i_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  m3i_pkg::item_t item,
    output logic           push,
    output m3i_pkg::fq_t   entry
);
    import m3i_pkg::*;

    elem_t [NELEM-1:0] e;
    logic              valid_reg;
    fq_t               entry_reg;

    assign e = {item.a22, item.a21, item.a20, item.a12, item.a11, item.a10,
                item.a02, item.a01, item.a00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < NPROD; i++)
            begin
                entry_reg.prod[i] <= PROD_W'(e[PROD_L[i]]) * PROD_W'(e[PROD_R[i]]);
            end
            for (int j = 0; j < NTOP; j++)
            begin
                entry_reg.top[j] <= e[j];
            end
        end
    end

    assign push  = valid_reg;
    assign entry = entry_reg;

endmodule

### rtl/core/m3i_queue.sv
// Short queue between the front end and the arithmetic back end.
// Depends on m3i_pkg and the assertion macros.
`include "matrix3_inverse_unit_macros.svh"
module m3i_queue #(
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  m3i_pkg::fq_t wdata,
    output logic         full,
    output logic         rvalid,
    output m3i_pkg::fq_t rdata
);
    import m3i_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fq_t              mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;
    logic             rvalid_reg;
    fq_t              rdata_reg;

    assign pop        = (count_reg != '0);
    assign count_next = count_reg + CNT_W'(push) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rvalid_reg <= pop;
            if (push)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
        if (pop)
        begin
            rdata_reg <= mem[rptr_reg];
        end
    end

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign rvalid = rvalid_reg;
    assign rdata  = rdata_reg;

    `M3I_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full)

endmodule

### rtl/core/m3i_cofdet.sv
// Back end, first half: cofactors, determinant, singular test, magnitudes.
// Depends on m3i_pkg.
module m3i_cofdet (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  m3i_pkg::fq_t  entry,
    input  m3i_pkg::eps_t eps,
    output logic          out_valid,
    output m3i_pkg::dv_t  dv
);
    import m3i_pkg::*;

    logic [3:0]        valid_reg;
    cof_t [NELEM-1:0]  cof1_reg;
    cof_t [NELEM-1:0]  cof2_reg;
    cof_t [NELEM-1:0]  cof3_reg;
    elem_t [NTOP-1:0]  top1_reg;
    pp_t [NTOP-1:0]    pl_reg;
    pp_t [NTOP-1:0]    ph_reg;
    det_t              det_reg;
    det_t              det_sum;
    det_t              det_abs;
    mag_t              thr;
    dv_t               dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_comb
    begin
        det_sum = '0;
        for (int j = 0; j < NTOP; j++)
        begin
            det_sum = det_sum + (DET_W'(ph_reg[j]) <<< ELEM_W) + DET_W'(pl_reg[j]);
        end
    end

    assign det_abs = det_reg[DET_W-1] ? -det_reg : det_reg;
    assign thr     = MAG_W'(eps) << (2 * FRAC_W);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NELEM; i++)
        begin
            cof1_reg[i] <= COF_W'(entry.prod[2*i]) - COF_W'(entry.prod[2*i+1]);
        end
        top1_reg <= entry.top;

        for (int j = 0; j < NTOP; j++)
        begin
            pl_reg[j] <= PP_W'(top1_reg[j])
                         * PP_W'($signed({1'b0, cof1_reg[3*j][ELEM_W-1:0]}));
            ph_reg[j] <= PP_W'(top1_reg[j])
                         * PP_W'($signed(cof1_reg[3*j][COF_W-1:ELEM_W]));
        end
        cof2_reg <= cof1_reg;

        det_reg  <= det_sum;
        cof3_reg <= cof2_reg;

        dv_reg.det_mag <= det_abs[MAG_W-1:0];
        dv_reg.det_neg <= det_reg[DET_W-1];
        dv_reg.sing    <= (det_abs[MAG_W-1:0] <= thr);
        for (int i = 0; i < NELEM; i++)
        begin
            dv_reg.num_neg[i] <= cof3_reg[i][COF_W-1];
            dv_reg.num_mag[i] <= MAG_W'(cof3_reg[i][COF_W-1] ? -cof3_reg[i] : cof3_reg[i])
                                 << (2 * FRAC_W);
        end
    end

    assign out_valid = valid_reg[3];
    assign dv        = dv_reg;

endmodule

### rtl/core/m3i_divider.sv
// Back end, second half: nine pipelined restoring dividers and saturation.
// Depends on m3i_pkg and the assertion macros.
`include "matrix3_inverse_unit_macros.svh"
module m3i_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  m3i_pkg::dv_t      dv,
    output logic              done,
    output m3i_pkg::result_t  result
);
    import m3i_pkg::*;

    localparam int WIDE_W = MAG_W + QUO_W;

    logic [QUO_W:0]    valid_reg;
    mag_t              det_reg  [QUO_W+1];
    logic              sing_reg [QUO_W+1];
    mag_t [NELEM-1:0]  rem_reg  [QUO_W+1];
    quo_t [NELEM-1:0]  q_reg    [QUO_W+1];
    logic [NELEM-1:0]  neg_reg  [QUO_W+1];
    logic [NELEM-1:0]  ovf_reg  [QUO_W+1];
    elem_t [NELEM-1:0] val;
    logic [NELEM-1:0]  sat;
    logic              done_reg;
    result_t           result_reg;
    quo_t              lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[QUO_W-1:0], in_valid};
            done_reg  <= valid_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg[0]  <= dv.det_mag;
        sing_reg[0] <= dv.sing;
        for (int i = 0; i < NELEM; i++)
        begin
            rem_reg[0][i] <= dv.num_mag[i];
            q_reg[0][i]   <= '0;
            neg_reg[0][i] <= dv.num_neg[i] ^ dv.det_neg;
            ovf_reg[0][i] <= (WIDE_W'(dv.num_mag[i]) >= (WIDE_W'(dv.det_mag) << QUO_W));
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int B = QUO_W - 1 - k;
        logic [WIDE_W-1:0] sh;

        assign sh = WIDE_W'(det_reg[k]) << B;

        always_ff @(posedge clk)
        begin
            det_reg[k+1]  <= det_reg[k];
            sing_reg[k+1] <= sing_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            ovf_reg[k+1]  <= ovf_reg[k];
            for (int i = 0; i < NELEM; i++)
            begin
                if (WIDE_W'(rem_reg[k][i]) >= sh)
                begin
                    rem_reg[k+1][i]  <= rem_reg[k][i] - sh[MAG_W-1:0];
                    q_reg[k+1][i]    <= q_reg[k][i] | (QUO_W'(1) << B);
                end
                else
                begin
                    rem_reg[k+1][i]  <= rem_reg[k][i];
                    q_reg[k+1][i]    <= q_reg[k][i];
                end
            end
        end
    end

    assign lim = QUO_W'(1) << (ELEM_W - 1);

    always_comb
    begin
        for (int i = 0; i < NELEM; i++)
        begin
            if (neg_reg[QUO_W][i])
            begin
                sat[i] = ovf_reg[QUO_W][i] || (q_reg[QUO_W][i] > lim);
                val[i] = sat[i] ? elem_t'(lim[ELEM_W-1:0])
                                : -elem_t'(q_reg[QUO_W][i][ELEM_W-1:0]);
            end
            else
            begin
                sat[i] = ovf_reg[QUO_W][i] || (q_reg[QUO_W][i] >= lim);
                val[i] = sat[i] ? elem_t'(lim[ELEM_W-1:0] - 1'b1)
                                : elem_t'(q_reg[QUO_W][i][ELEM_W-1:0]);
            end
            if (sing_reg[QUO_W])
            begin
                sat[i] = 1'b0;
                val[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.b00       <= val[0];
        result_reg.b01       <= val[1];
        result_reg.b02       <= val[2];
        result_reg.b10       <= val[3];
        result_reg.b11       <= val[4];
        result_reg.b12       <= val[5];
        result_reg.b20       <= val[6];
        result_reg.b21       <= val[7];
        result_reg.b22       <= val[8];
        result_reg.singular  <= sing_reg[QUO_W];
        result_reg.saturated <= |sat;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `M3I_ASSERT_IMP(a_sing_clean, clk, rst_n, done,
        !(result.singular && result.saturated))

endmodule

### rtl/core/matrix3_inverse_unit.sv
// matrix3_inverse_unit: 3x3 signed fixed-point inverse, exact truncated quotients.
// Throughput: one matrix per cycle; with QUEUE_DEPTH of 2 or more busy never rises, as the back end never stalls.
// The 33 quotient stages of the nine restoring dividers make up most of the latency.
// Reset (rst_n low, asynchronous) empties the pipeline and sets det_epsilon to 1.
// Depends on m3i_pkg, m3i_front, m3i_queue, m3i_cofdet, m3i_divider.
`include "matrix3_inverse_unit_macros.svh"
module matrix3_inverse_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  m3i_pkg::item_t    item,
    input  logic              cfg_we,
    input  m3i_pkg::eps_t     cfg_wdata,
    output logic              done,
    output m3i_pkg::result_t  result
);
    import m3i_pkg::*;

    localparam int LATENCY = QUO_W + 9;

    eps_t  eps_reg;
    logic  accept;
    logic  push;
    fq_t   entry;
    logic  full;
    logic  q_valid;
    fq_t   q_data;
    logic  cd_valid;
    dv_t   dv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_W'(1);
        end
        else if (cfg_we)
        begin
            eps_reg <= cfg_wdata;
        end
    end

    assign busy   = full;
    assign accept = start && !busy;

    m3i_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push),
        .entry  (entry)
    );

    m3i_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (entry),
        .full   (full),
        .rvalid (q_valid),
        .rdata  (q_data)
    );

    m3i_cofdet u_cofdet (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .entry     (q_data),
        .eps       (eps_reg),
        .out_valid (cd_valid),
        .dv        (dv)
    );

    m3i_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cd_valid),
        .dv       (dv),
        .done     (done),
        .result   (result)
    );

    `M3I_ASSERT_DLY(a_latency, clk, rst_n, accept, LATENCY, done)

endmodule
